@@ hw/rtl/rcc_pkg.sv @@
// shared types, constants and sequencer states of the carryless range encoder
`default_nettype none
package rcc_pkg;

  localparam int unsigned PROB_BITS_DEF = 16;

  localparam logic [16:0] TOT_RESET   = 17'h10000;
  localparam logic [31:0] RANGE_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] LOW_RESET   = 32'h0000_0000;

  localparam logic [2:0] MAX_BYTES = 3'd4;
  localparam logic [2:0] LAST_BYTE = 3'd3;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] cumulative_frequency;
    logic [16:0] symbol_frequency;
  } sym_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_LOW,
    ST_MUL_RANGE,
    ST_LOAD,
    ST_NORM,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/range_encoder_carryless_core.sv @@
// top level of the carryless range encoder: sequencer, state registers and output stage
`default_nettype none
// Carryless 32-bit range encoder. Each request either encodes one symbol interval
// or flushes the four bytes of low and returns the coder to its reset state. An
// encode request passes through acceptance, the bit-serial divider (range by
// total_frequency, one quotient bit a cycle), the shared multiplier for low and
// range, then one normalization step per byte and a final step to close the run.
// The block takes no request while one is in progress; the output register
// lets the next request start while the final byte still waits.
// total_frequency may be written only while the block is idle; 0 acts as 1.
module range_encoder_carryless_core #(
  parameter int unsigned PROB_BITS = rcc_pkg::PROB_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sym_valid,
  output logic               sym_stall,
  input  wire rcc_pkg::sym_t sym,
  output logic               code_valid,
  input  wire logic          code_stall,
  output rcc_pkg::code_t     code,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [16:0]   cfg_data
);

  localparam logic [31:0] BOTTOM = 32'd1 << PROB_BITS;
  localparam logic [31:0] BOT_MASK = BOTTOM - 32'd1;

  rcc_pkg::state_t state, state_next;

  logic [16:0] total;
  logic [31:0] low;
  logic [31:0] range;
  logic [15:0] cum;
  logic [16:0] freq;
  logic [2:0]  n;
  logic        pend_valid;
  logic [7:0]  pend_byte;

  logic        accept;
  logic        out_free;
  logic        out_load;
  logic        div_start;
  logic        div_done;
  logic [31:0] quot;
  logic [16:0] divisor;
  logic [16:0] mul_b;
  logic [31:0] prod;

  logic [31:0] sum;
  logic        same;
  logic        norm_go;
  logic [31:0] range_clamped;

  assign accept   = sym_valid && !sym_stall;
  assign out_free = !code_valid || !code_stall;
  assign out_load = out_free && (((state == rcc_pkg::ST_NORM) && pend_valid) ||
                                 (state == rcc_pkg::ST_FLUSH));
  assign divisor  = (total == 17'd0) ? 17'd1 : total;
  assign cfg_ready = 1'b1;

  assign sum           = low + range;
  assign same          = (low[31:24] == sum[31:24]);
  assign norm_go       = (same || (range < BOTTOM)) && (n < rcc_pkg::MAX_BYTES);
  assign range_clamped = same ? range : ((32'd0 - low) & BOT_MASK);

  rcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (range),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quot)
  );

  rcc_mul u_mul (
    .clk  (clk),
    .a    (quot),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    state_next = state;
    case (state)
      rcc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (sym.opcode == rcc_pkg::OP_FLUSH) ? rcc_pkg::ST_FLUSH
                                                         : rcc_pkg::ST_DIV;
        end
      end
      rcc_pkg::ST_DIV: begin
        if (div_done) state_next = rcc_pkg::ST_MUL_LOW;
      end
      rcc_pkg::ST_MUL_LOW:   state_next = rcc_pkg::ST_MUL_RANGE;
      rcc_pkg::ST_MUL_RANGE: state_next = rcc_pkg::ST_LOAD;
      rcc_pkg::ST_LOAD:      state_next = rcc_pkg::ST_NORM;
      rcc_pkg::ST_NORM: begin
        if (!norm_go && (!pend_valid || out_free)) state_next = rcc_pkg::ST_IDLE;
      end
      rcc_pkg::ST_FLUSH: begin
        if (out_free && (n == rcc_pkg::LAST_BYTE)) state_next = rcc_pkg::ST_IDLE;
      end
      default: state_next = rcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sym_stall = (state != rcc_pkg::ST_IDLE);
    div_start = 1'b0;
    mul_b     = freq;
    case (state)
      rcc_pkg::ST_IDLE:    div_start = sym_valid && (sym.opcode == rcc_pkg::OP_ENCODE);
      rcc_pkg::ST_MUL_LOW: mul_b = {1'b0, cum};
      default:             mul_b = freq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rcc_pkg::ST_IDLE;
      total      <= rcc_pkg::TOT_RESET;
      low        <= rcc_pkg::LOW_RESET;
      range      <= rcc_pkg::RANGE_RESET;
      code_valid <= 1'b0;
      pend_valid <= 1'b0;
      n          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) total <= cfg_data;
      if (out_load) code_valid <= 1'b1;
      else if (!code_stall) code_valid <= 1'b0;
      case (state)
        rcc_pkg::ST_IDLE: begin
          if (accept) begin
            cum  <= sym.cumulative_frequency;
            freq <= sym.symbol_frequency;
            n    <= '0;
          end
        end
        rcc_pkg::ST_MUL_RANGE: low <= low + prod;
        rcc_pkg::ST_LOAD:      range <= prod;
        rcc_pkg::ST_NORM: begin
          // one byte held back so the last one of the run can be marked
          if (norm_go) begin
            if (!pend_valid || out_free) begin
              pend_byte  <= low[31:24];
              pend_valid <= 1'b1;
              low        <= low << 8;
              range      <= range_clamped << 8;
              n          <= n + 3'd1;
              if (pend_valid) begin
                code.out_byte    <= pend_byte;
                code.last_of_run <= 1'b0;
              end
            end
          end else if (pend_valid && out_free) begin
            code.out_byte    <= pend_byte;
            code.last_of_run <= 1'b1;
            pend_valid       <= 1'b0;
          end
        end
        rcc_pkg::ST_FLUSH: begin
          if (out_free) begin
            code.out_byte    <= low[31:24];
            code.last_of_run <= (n == rcc_pkg::LAST_BYTE);
            n                <= n + 3'd1;
            if (n == rcc_pkg::LAST_BYTE) begin
              low   <= rcc_pkg::LOW_RESET;
              range <= rcc_pkg::RANGE_RESET;
            end else begin
              low <= low << 8;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == rcc_pkg::ST_IDLE) |-> !pend_valid)
    else $error("pending byte left behind at end of request");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == rcc_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_flush_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && (sym.opcode == rcc_pkg::OP_FLUSH)) |=> (state == rcc_pkg::ST_FLUSH))
    else $error("flush request did not enter flush");

  a_byte_cap: assert property (@(posedge clk) disable iff (rst)
    n <= rcc_pkg::MAX_BYTES)
    else $error("more than four bytes emitted for one request");

endmodule
`default_nettype wire

@@ hw/rtl/rcc_div.sv @@
// radix-2 restoring divider, 32-bit dividend by 17-bit divisor, one quotient bit a cycle
`default_nettype none
module rcc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0] q;
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        active;
  logic [17:0] rem_sh;
  logic [18:0] diff;
  logic        ge;
  logic [16:0] dvs;

  assign rem_sh   = {rem, q[31]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge       = ~diff[18];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q      <= dividend;
        rem    <= '0;
        dvs    <= divisor;
        cnt    <= '0;
        active <= 1'b1;
      end else if (active) begin
        rem <= ge ? diff[16:0] : rem_sh[16:0];
        q   <= {q[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/rcc_mul.sv @@
// registered 32x17 multiplier keeping the low 32 bits of the product
`default_nettype none
module rcc_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [16:0] b,
  output logic [31:0]      prod
);

  logic [48:0] full;

  assign full = {17'd0, a} * {32'd0, b};

  always_ff @(posedge clk) begin
    prod <= full[31:0];
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the carryless range encoder core
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PROB_BITS     = rcc_pkg::PROB_BITS_DEF;
  localparam logic [31:0] TOP_BYTE_MASK = 32'hFF00_0000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 60;

  class byte_stream_model;
    logic [16:0]    total;
    logic [31:0]    lo;
    logic [31:0]    span;
    rcc_pkg::code_t expected_bytes[$];
    int             mismatches;

    function new();
      total      = rcc_pkg::TOT_RESET;
      lo         = rcc_pkg::LOW_RESET;
      span       = rcc_pkg::RANGE_RESET;
      mismatches = 0;
    endfunction

    function void set_total(logic [16:0] v);
      total = v;
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // works out the bytes one accepted request produces
    function void note_request(rcc_pkg::sym_t s);
      logic [31:0]    q;
      logic [31:0]    bottom;
      rcc_pkg::code_t c;
      rcc_pkg::code_t run[$];
      bottom = 32'd1 << PROB_BITS;
      if (s.opcode == rcc_pkg::OP_FLUSH) begin
        repeat (rcc_pkg::MAX_BYTES) begin
          c.out_byte    = lo[31:24];
          c.last_of_run = 1'b0;
          run = {run, c};
          lo = lo << 8;
        end
        lo   = rcc_pkg::LOW_RESET;
        span = rcc_pkg::RANGE_RESET;
      end else begin
        // a zero total divides as one
        q    = span / ((total == 17'd0) ? 32'd1 : {15'd0, total});
        lo   = lo + q * s.cumulative_frequency;
        span = q * s.symbol_frequency;
        while (run.size() < rcc_pkg::MAX_BYTES) begin
          if (((lo ^ (lo + span)) & TOP_BYTE_MASK) != 32'd0) begin
            if (span >= bottom) break;
            // carryless clamp to what is left below the next boundary
            span = (32'd0 - lo) & (bottom - 32'd1);
          end
          c.out_byte    = lo[31:24];
          c.last_of_run = 1'b0;
          run = {run, c};
          lo   = lo << 8;
          span = span << 8;
        end
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      expected_bytes = {expected_bytes, run};
    endfunction

    function void check_byte(rcc_pkg::code_t got);
      rcc_pkg::code_t want;
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last_of_run));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        note_failure($sformatf("out_byte expected %02h got %02h", want.out_byte, got.out_byte));
      if (got.last_of_run !== want.last_of_run)
        note_failure($sformatf("last_of_run expected %0b got %0b (byte %02h)",
                               want.last_of_run, got.last_of_run, want.out_byte));
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           sym_valid = 1'b0;
  logic           sym_stall;
  rcc_pkg::sym_t  sym = '0;
  logic           code_valid;
  logic           code_stall = 1'b0;
  rcc_pkg::code_t code;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [16:0]    cfg_data = '0;

  logic [16:0]    cur_total = rcc_pkg::TOT_RESET;
  int unsigned    cycle_count = 0;
  int             stall_mode = 0;
  byte_stream_model coder = new();

  range_encoder_carryless_core #(.PROB_BITS(PROB_BITS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .sym_valid  (sym_valid),
    .sym_stall  (sym_stall),
    .sym        (sym),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("range_encoder_carryless_core verification failed");
      $finish;
    end
  end

  // receiver backpressure, mode picked anew whenever the low byte of cycle_count is zero
  always @(posedge clk) begin
    if (cycle_count[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: code_stall <= 1'b0;
      1: code_stall <= ($urandom_range(0, 3) == 0);
      2: code_stall <= ($urandom_range(0, 1) == 1);
      default: code_stall <= (cycle_count[3:0] < 4'd6);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) coder.set_total(cfg_data);
      if (sym_valid && !sym_stall) coder.note_request(sym);
      if (code_valid && !code_stall) coder.check_byte(code);
    end
  end

  task automatic send_request(rcc_pkg::sym_t s);
    sym_valid <= 1'b1;
    sym       <= s;
    @(posedge clk);
    while (sym_stall) @(posedge clk);
  endtask

  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      sym_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_total = v;
  endtask

  // wait for every outstanding byte, then let a zero-byte encode finish
  task automatic drain();
    sym_valid <= 1'b0;
    @(posedge clk);
    while (coder.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic rcc_pkg::sym_t make_request();
    rcc_pkg::sym_t s;
    int            kind;
    int            tot;
    int            f;
    int            cmax;
    kind = $urandom_range(0, 99);
    s.opcode               = rcc_pkg::OP_ENCODE;
    s.cumulative_frequency = 16'($urandom);
    s.symbol_frequency     = 17'($urandom);
    if (kind < 6) begin
      s.opcode = rcc_pkg::OP_FLUSH;
    end else if (kind >= 20) begin
      // consistent interval inside the current total
      tot = (cur_total == 17'd0) ? 1 : int'(cur_total);
      case ($urandom_range(0, 2))
        0: f = $urandom_range(1, (tot < 16) ? tot : 16);
        1: f = $urandom_range(1, tot);
        default: f = tot - $urandom_range(0, (tot < 16) ? tot - 1 : 15);
      endcase
      cmax = tot - f;
      if (cmax > 65535) cmax = 65535;
      s.symbol_frequency     = 17'(f);
      s.cumulative_frequency = 16'($urandom_range(0, cmax));
    end
    return s;
  endfunction

  task automatic run_phase(int count, bit bursty);
    int burst;
    burst = $urandom_range(1, 8);
    repeat (count) begin
      send_request(make_request());
      burst--;
      if (burst == 0) begin
        if (bursty) sender_gap($urandom_range(0, 10));
        burst = $urandom_range(1, 8);
      end
    end
  endtask

  rcc_pkg::sym_t directed [16] = '{
    '{rcc_pkg::OP_ENCODE, 16'h0000, 17'h10000},
    '{rcc_pkg::OP_ENCODE, 16'hFFFF, 17'h00001},
    '{rcc_pkg::OP_ENCODE, 16'h0000, 17'h00001},
    '{rcc_pkg::OP_ENCODE, 16'h8000, 17'h08000},
    '{rcc_pkg::OP_ENCODE, 16'h0000, 17'h00000},
    '{rcc_pkg::OP_FLUSH,  16'hFFFF, 17'h1FFFF},
    '{rcc_pkg::OP_ENCODE, 16'hFFFF, 17'h1FFFF},
    '{rcc_pkg::OP_ENCODE, 16'hAAAA, 17'h15555},
    '{rcc_pkg::OP_ENCODE, 16'h5555, 17'h0AAAA},
    '{rcc_pkg::OP_ENCODE, 16'h1234, 17'h00010},
    '{rcc_pkg::OP_ENCODE, 16'h0001, 17'h00002},
    '{rcc_pkg::OP_ENCODE, 16'hFFF0, 17'h00001},
    '{rcc_pkg::OP_FLUSH,  16'h0000, 17'h00000},
    '{rcc_pkg::OP_ENCODE, 16'h7FFF, 17'h00100},
    '{rcc_pkg::OP_ENCODE, 16'h0100, 17'h00003},
    '{rcc_pkg::OP_FLUSH,  16'h5555, 17'h0AAAA}
  };

  logic [16:0] totals [9] = '{17'd1, 17'd0, 17'h1FFFF, 17'h10000, 17'd3, 17'd1000,
                              17'd0, 17'd40000, 17'hFFFF};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_request(directed[i]);
      if (i % 4 == 3) sender_gap($urandom_range(1, 6));
    end
    drain();
    totals[6] = 17'($urandom_range(2, 131071));
    foreach (totals[i]) begin
      cfg_write(totals[i]);
      run_phase(34, i != 3);
      drain();
    end
    if (coder.mismatches == 0 && coder.expected_bytes.size() == 0)
      $display("range_encoder_carryless_core verification clean");
    else
      $display("range_encoder_carryless_core verification failed");
    $finish;
  end

endmodule
`default_nettype wire
